[rtl/core/dual_sensor_safety_watchdog_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual sensor safety watchdog
// Clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_SENSOR_SAFETY_WATCHDOG_MACROS_SVH
`define DUAL_SENSOR_SAFETY_WATCHDOG_MACROS_SVH

// Same-cycle implication
`define DSW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define DSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dsw_pkg.sv]
// ----------------------------------------------------------------------------
// dsw_pkg
// Shared types and codes of the dual sensor safety watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsw_pkg;

    // Request codes of an input item
    localparam logic [2:0] REQ_RANGER_BEAT   = 3'd0;
    localparam logic [2:0] REQ_INERTIAL_BEAT = 3'd1;
    localparam logic [2:0] REQ_TICK          = 3'd2;
    localparam logic [2:0] REQ_RANGER_READ   = 3'd3;
    localparam logic [2:0] REQ_INERTIAL_READ = 3'd4;
    localparam logic [2:0] REQ_QUERY         = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_HB_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_R_DEADLINE    = 3'd1;
    localparam logic [2:0] REG_I_DEADLINE    = 3'd2;
    localparam logic [2:0] REG_GRACE         = 3'd3;
    localparam logic [2:0] REG_MAX_PROMPTS   = 3'd4;
    localparam logic [2:0] REG_OBSTACLE_THR  = 3'd5;

    localparam int APB_ADDR_W = 5;

    typedef enum logic [1:0] {
        HEALTH_OK       = 2'd0,
        HEALTH_DEGRADED = 2'd1,
        HEALTH_DEAD     = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_DEGRADED  = 2'd1,
        MODE_SAFE_STOP = 2'd2,
        MODE_RECOVERY  = 2'd3
    } mode_t;

    // Register file contents
    typedef struct packed {
        logic [15:0] hb_timeout;
        logic [15:0] r_deadline;
        logic [15:0] i_deadline;
        logic [15:0] grace;
        logic [2:0]  max_prompts;
        logic [15:0] obstacle_thr;
    } cfg_t;

    // Per-source view of the configuration
    typedef struct packed {
        logic [15:0] timeout;
        logic [15:0] deadline;
        logic [15:0] grace;
        logic [2:0]  max_prompts;
    } src_cfg_t;

    // What the current item means to one source
    typedef struct packed {
        logic beat;
        logic tick;
        logic read;
    } src_ctl_t;

    // Source status after the current item
    typedef struct packed {
        logic        alive;
        health_t     data_health;
        health_t     health;
        logic [31:0] age;
        logic        prompt;
        logic [2:0]  prompt_count;
    } src_stat_t;

endpackage

`default_nettype wire

[rtl/core/dsw_regs.sv]
// ----------------------------------------------------------------------------
// dsw_regs
// APB register file holding the watchdog thresholds and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsw_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output dsw_pkg::cfg_t                     cfg
);
    import dsw_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_HB_TIMEOUT:   cfg_next.hb_timeout   = pwdata[15:0];
                REG_R_DEADLINE:   cfg_next.r_deadline   = pwdata[15:0];
                REG_I_DEADLINE:   cfg_next.i_deadline   = pwdata[15:0];
                REG_GRACE:        cfg_next.grace        = pwdata[15:0];
                REG_MAX_PROMPTS:  cfg_next.max_prompts  = pwdata[2:0];
                REG_OBSTACLE_THR: cfg_next.obstacle_thr = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, reset to the default limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hb_timeout   <= 16'd250;
            cfg_reg.r_deadline   <= 16'd300;
            cfg_reg.i_deadline   <= 16'd300;
            cfg_reg.grace        <= 16'd2000;
            cfg_reg.max_prompts  <= 3'd3;
            cfg_reg.obstacle_thr <= 16'd200;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_HB_TIMEOUT:   prdata = {16'd0, cfg_reg.hb_timeout};
            REG_R_DEADLINE:   prdata = {16'd0, cfg_reg.r_deadline};
            REG_I_DEADLINE:   prdata = {16'd0, cfg_reg.i_deadline};
            REG_GRACE:        prdata = {16'd0, cfg_reg.grace};
            REG_MAX_PROMPTS:  prdata = {29'd0, cfg_reg.max_prompts};
            REG_OBSTACLE_THR: prdata = {16'd0, cfg_reg.obstacle_thr};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/dsw_source.sv]
// ----------------------------------------------------------------------------
// dsw_source
// Heartbeat watchdog, reading deadline and recovery prompting of one source.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsw_source #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire dsw_pkg::src_ctl_t     ctl,
    input  wire logic [TIME_BITS-1:0]  now,
    input  wire dsw_pkg::src_cfg_t     cfg,
    output dsw_pkg::src_stat_t         stat
);
    import dsw_pkg::*;

    logic                 alive_reg, alive_next;
    logic                 beat_seen_reg, beat_seen_next;
    logic [TIME_BITS-1:0] last_beat_reg, last_beat_next;
    logic                 read_seen_reg, read_seen_next;
    logic [TIME_BITS-1:0] last_read_reg, last_read_next;
    health_t              data_health_reg, data_health_next;
    logic                 recovering_reg, recovering_next;
    logic [TIME_BITS-1:0] rstart_reg, rstart_next;
    logic [2:0]           count_reg, count_next;

    logic [TIME_BITS-1:0] beat_age;
    logic [TIME_BITS-1:0] read_age;
    logic [TIME_BITS-1:0] rec_age;
    logic                 wd_fire;
    logic                 alive_wd;
    logic                 recov_wd;
    logic                 grace_met;
    logic                 prompt;
    health_t              dh_tick;

    // Ages, wrapping at the time width
    assign beat_age = now - last_beat_reg;
    assign read_age = now - last_read_reg;
    assign rec_age  = now - rstart_reg;

    // Watchdog: a live source whose heartbeat is too old dies now
    assign wd_fire  = ctl.tick && beat_seen_reg && alive_reg
                      && (beat_age > TIME_BITS'(cfg.timeout));
    assign alive_wd = alive_reg && !wd_fire;
    assign recov_wd = recovering_reg || wd_fire;

    // Grace time counts from death or the last prompt
    assign grace_met = wd_fire ? (cfg.grace == 16'd0)
                               : (rec_age >= TIME_BITS'(cfg.grace));
    assign prompt    = ctl.tick && !alive_wd && recov_wd && grace_met
                       && (count_reg < cfg.max_prompts);

    // Data health on a tick
    always_comb begin
        if (!read_seen_reg) begin
            dh_tick = HEALTH_DEAD;
        end else if (read_age > TIME_BITS'(cfg.deadline)) begin
            dh_tick = HEALTH_DEGRADED;
        end else begin
            dh_tick = HEALTH_OK;
        end
    end

    // State update for the current item
    always_comb begin
        alive_next       = alive_reg;
        beat_seen_next   = beat_seen_reg;
        last_beat_next   = last_beat_reg;
        read_seen_next   = read_seen_reg;
        last_read_next   = last_read_reg;
        data_health_next = data_health_reg;
        recovering_next  = recovering_reg;
        rstart_next      = rstart_reg;
        count_next       = count_reg;
        if (ctl.beat) begin
            last_beat_next = now;
            beat_seen_next = 1'b1;
            if (!alive_reg) begin
                alive_next      = 1'b1;
                recovering_next = 1'b0;
                count_next      = 3'd0;
            end
        end
        if (ctl.tick) begin
            alive_next       = alive_wd;
            recovering_next  = recov_wd;
            data_health_next = dh_tick;
            if (wd_fire || prompt) begin
                rstart_next = now;
            end
            if (prompt) begin
                count_next = count_reg + 3'd1;
            end
        end
        if (ctl.read) begin
            last_read_next = now;
            read_seen_next = 1'b1;
        end
    end

    // Advance the source state on each transfer into the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg       <= 1'b0;
            beat_seen_reg   <= 1'b0;
            read_seen_reg   <= 1'b0;
            data_health_reg <= HEALTH_DEAD;
            recovering_reg  <= 1'b0;
            count_reg       <= 3'd0;
        end else if (step) begin
            alive_reg       <= alive_next;
            beat_seen_reg   <= beat_seen_next;
            read_seen_reg   <= read_seen_next;
            data_health_reg <= data_health_next;
            recovering_reg  <= recovering_next;
            count_reg       <= count_next;
        end
    end

    // Timestamps only matter once their flag is set
    always_ff @(posedge aclk) begin
        if (step) begin
            last_beat_reg <= last_beat_next;
            last_read_reg <= last_read_next;
            rstart_reg    <= rstart_next;
        end
    end

    // Status after this item
    always_comb begin
        stat.alive        = alive_next;
        stat.data_health  = data_health_next;
        stat.health       = alive_next ? data_health_next : HEALTH_DEAD;
        stat.age          = (read_seen_reg && !ctl.read) ? 32'(read_age) : 32'd0;
        stat.prompt       = prompt;
        stat.prompt_count = count_next;
    end

endmodule

`default_nettype wire

[rtl/core/dual_sensor_safety_watchdog.sv]
// Dual sensor safety watchdog. Takes one item per clock (heartbeat, tick,
// reading or query for the ranger or inertial source) and returns one status
// snapshot per item. Throughput is one item per cycle while the result side
// is not stalled: each item is captured in an input register, and the whole
// source state (watchdogs, deadlines, recovery prompts, mode and obstacle
// override) is updated in the single cycle that moves it into the result
// register. Either side may stall freely; no clearing pass is needed after
// reset. Times wrap at TIME_BITS bits.
// ----------------------------------------------------------------------------
// dual_sensor_safety_watchdog
// Two-source heartbeat, staleness and recovery supervisor with system mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_sensor_safety_watchdog #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dsw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    // input channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [2:0]                     s_req_type,
    input  wire logic [31:0]                    s_now_ms,
    input  wire logic [15:0]                    s_distance_mm,
    input  wire logic                           s_ranger_connected,
    input  wire logic                           s_inertial_valid,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_system_mode,
    output logic                                m_override_on,
    output logic [1:0]                          m_ranger_health,
    output logic [1:0]                          m_inertial_health,
    output logic signed [16:0]                  m_last_distance_mm,
    output logic [31:0]                         m_ranger_age_ms,
    output logic [31:0]                         m_inertial_age_ms,
    output logic                                m_ranger_prompt,
    output logic                                m_inertial_prompt,
    output logic [2:0]                          m_ranger_prompts_used,
    output logic [2:0]                          m_inertial_prompts_used
);
    import dsw_pkg::*;
    `include "dual_sensor_safety_watchdog_macros.svh"

    cfg_t                 cfg;
    src_cfg_t             r_cfg, i_cfg;
    src_ctl_t             r_ctl, i_ctl;
    src_stat_t            r_stat, i_stat;

    // input stage
    logic                 in_valid_reg, in_valid_next;
    logic [2:0]           req_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [15:0]          dist_reg;
    logic                 conn_reg;
    logic                 accept;
    logic                 adv;

    // block-level state
    mode_t                mode_reg, mode_next;
    logic                 override_reg, override_next;
    logic [16:0]          distance_reg, distance_next;

    // result stage
    logic                 m_valid_reg, m_valid_next;
    mode_t                m_system_mode_reg;
    logic                 m_override_on_reg;
    logic [1:0]           m_ranger_health_reg;
    logic [1:0]           m_inertial_health_reg;
    logic [16:0]          m_last_distance_mm_reg;
    logic [31:0]          m_ranger_age_ms_reg;
    logic [31:0]          m_inertial_age_ms_reg;
    logic                 m_ranger_prompt_reg;
    logic                 m_inertial_prompt_reg;
    logic [2:0]           m_ranger_prompts_used_reg;
    logic [2:0]           m_inertial_prompts_used_reg;

    dsw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the input stage frees up whenever its item moves on
    assign adv           = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || adv;
    assign accept        = s_valid && s_ready;
    assign in_valid_next = accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign m_valid_next  = adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req_type;
            now_reg  <= TIME_BITS'(s_now_ms);
            dist_reg <= s_distance_mm;
            conn_reg <= s_ranger_connected;
        end
    end

    // Route the request to each source
    always_comb begin
        r_ctl.beat = (req_reg == REQ_RANGER_BEAT);
        r_ctl.tick = (req_reg == REQ_TICK);
        r_ctl.read = (req_reg == REQ_RANGER_READ);
        i_ctl.beat = (req_reg == REQ_INERTIAL_BEAT);
        i_ctl.tick = (req_reg == REQ_TICK);
        i_ctl.read = (req_reg == REQ_INERTIAL_READ);
        r_cfg.timeout     = cfg.hb_timeout;
        r_cfg.deadline    = cfg.r_deadline;
        r_cfg.grace       = cfg.grace;
        r_cfg.max_prompts = cfg.max_prompts;
        i_cfg.timeout     = cfg.hb_timeout;
        i_cfg.deadline    = cfg.i_deadline;
        i_cfg.grace       = cfg.grace;
        i_cfg.max_prompts = cfg.max_prompts;
    end

    dsw_source #(.TIME_BITS(TIME_BITS)) u_ranger (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .ctl     (r_ctl),
        .now     (now_reg),
        .cfg     (r_cfg),
        .stat    (r_stat)
    );

    dsw_source #(.TIME_BITS(TIME_BITS)) u_inertial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .ctl     (i_ctl),
        .now     (now_reg),
        .cfg     (i_cfg),
        .stat    (i_stat)
    );

    // Mode on a tick, obstacle override on a connected ranger reading
    always_comb begin
        mode_next     = mode_reg;
        override_next = override_reg;
        distance_next = distance_reg;
        if (req_reg == REQ_TICK) begin
            if (!r_stat.alive || !i_stat.alive) begin
                mode_next = MODE_SAFE_STOP;
            end else if (r_stat.data_health != HEALTH_OK
                         || i_stat.data_health != HEALTH_OK) begin
                mode_next = MODE_DEGRADED;
            end else begin
                mode_next = MODE_NORMAL;
            end
        end
        if (req_reg == REQ_RANGER_READ && conn_reg) begin
            distance_next = {1'b0, dist_reg};
            override_next = (dist_reg < cfg.obstacle_thr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RECOVERY;
            override_reg <= 1'b0;
            distance_reg <= 17'h1FFFF;
        end else if (adv) begin
            mode_reg     <= mode_next;
            override_reg <= override_next;
            distance_reg <= distance_next;
        end
    end

    // Load the result snapshot
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_system_mode_reg           <= mode_next;
            m_override_on_reg           <= override_next;
            m_ranger_health_reg         <= r_stat.health;
            m_inertial_health_reg       <= i_stat.health;
            m_last_distance_mm_reg      <= distance_next;
            m_ranger_age_ms_reg         <= r_stat.age;
            m_inertial_age_ms_reg       <= i_stat.age;
            m_ranger_prompt_reg         <= r_stat.prompt;
            m_inertial_prompt_reg       <= i_stat.prompt;
            m_ranger_prompts_used_reg   <= r_stat.prompt_count;
            m_inertial_prompts_used_reg <= i_stat.prompt_count;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_system_mode           = m_system_mode_reg;
    assign m_override_on           = m_override_on_reg;
    assign m_ranger_health         = m_ranger_health_reg;
    assign m_inertial_health       = m_inertial_health_reg;
    assign m_last_distance_mm      = $signed(m_last_distance_mm_reg);
    assign m_ranger_age_ms         = m_ranger_age_ms_reg;
    assign m_inertial_age_ms       = m_inertial_age_ms_reg;
    assign m_ranger_prompt         = m_ranger_prompt_reg;
    assign m_inertial_prompt       = m_inertial_prompt_reg;
    assign m_ranger_prompts_used   = m_ranger_prompts_used_reg;
    assign m_inertial_prompts_used = m_inertial_prompts_used_reg;

    // Checks
    `DSW_ASSERT_NEXT(a_adv_loads_result, adv, m_valid_reg, "result not loaded after advance")
    `DSW_ASSERT_SAME(a_stall_only_full, !s_ready, in_valid_reg && m_valid_reg && !m_ready, "input stalled without a full pipe")
    `DSW_ASSERT_SAME(a_r_prompt_stop, m_valid_reg && m_ranger_prompt_reg, m_system_mode_reg == MODE_SAFE_STOP && m_ranger_health_reg == HEALTH_DEAD, "ranger prompt while not in safe stop")
    `DSW_ASSERT_SAME(a_i_prompt_stop, m_valid_reg && m_inertial_prompt_reg, m_system_mode_reg == MODE_SAFE_STOP && m_inertial_health_reg == HEALTH_DEAD, "inertial prompt while not in safe stop")

endmodule

`default_nettype wire

[sim/dual_sensor_safety_watchdog_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sensor_safety_watchdog_tb
// Self-checking bench for the two-source safety supervisor. A bit-accurate
// predictor of heartbeat watchdogs, reading deadlines, recovery prompts, mode
// and obstacle override runs on each accepted input transfer; every status
// snapshot is compared field by field against it. Directed items at reset
// settings come first, then random sequences under several register settings.
// ----------------------------------------------------------------------------
module dual_sensor_safety_watchdog_tb;
    import dsw_pkg::*;

    // Codes the block treats as plain queries, and a register slot it ignores
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam logic [2:0] REG_SPARE   = 3'd6;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] now;
        logic [15:0] range_mm;
        logic        connected;
        logic        imu_ok;
    } sensor_item_t;

    typedef struct {
        mode_t              mode;
        logic               override_on;
        health_t            r_health;
        health_t            i_health;
        logic signed [16:0] distance;
        logic [31:0]        r_age;
        logic [31:0]        i_age;
        logic               r_prompt;
        logic               i_prompt;
        logic [2:0]         r_used;
        logic [2:0]         i_used;
    } snapshot_t;

    typedef struct {
        logic        alive;
        logic        beat_seen;
        logic [31:0] last_beat;
        logic        read_seen;
        logic [31:0] last_read;
        health_t     data_health;
        logic        recovering;
        logic [31:0] rec_start;
        logic [2:0]  prompts;
    } source_track_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type         = '0;
    logic [31:0] s_now_ms           = '0;
    logic [15:0] s_distance_mm      = '0;
    logic        s_ranger_connected = 1'b0;
    logic        s_inertial_valid   = 1'b0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_system_mode;
    logic               m_override_on;
    logic [1:0]         m_ranger_health;
    logic [1:0]         m_inertial_health;
    logic signed [16:0] m_last_distance_mm;
    logic [31:0]        m_ranger_age_ms;
    logic [31:0]        m_inertial_age_ms;
    logic               m_ranger_prompt;
    logic               m_inertial_prompt;
    logic [2:0]         m_ranger_prompts_used;
    logic [2:0]         m_inertial_prompts_used;

    // Predictor copy of the registers, at reset values
    logic [15:0] hb_timeout_cfg   = 16'd250;
    logic [15:0] r_deadline_cfg   = 16'd300;
    logic [15:0] i_deadline_cfg   = 16'd300;
    logic [15:0] grace_cfg        = 16'd2000;
    logic [2:0]  max_prompts_cfg  = 3'd3;
    logic [15:0] obstacle_cfg     = 16'd200;

    // Predictor copy of the supervisor state
    source_track_t      ranger_st;
    source_track_t      inertial_st;
    mode_t              mode_m     = MODE_RECOVERY;
    logic               override_m = 1'b0;
    logic signed [16:0] distance_m = 17'h1FFFF;

    sensor_item_t item_q[$];
    snapshot_t    snapshot_q[$];
    sensor_item_t offered;

    int send_gap       = 0;
    int send_burst     = 0;
    int recv_gap       = 0;
    int recv_burst     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int snapshots_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    dual_sensor_safety_watchdog u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_now_ms               (s_now_ms),
        .s_distance_mm          (s_distance_mm),
        .s_ranger_connected     (s_ranger_connected),
        .s_inertial_valid       (s_inertial_valid),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_system_mode          (m_system_mode),
        .m_override_on          (m_override_on),
        .m_ranger_health        (m_ranger_health),
        .m_inertial_health      (m_inertial_health),
        .m_last_distance_mm     (m_last_distance_mm),
        .m_ranger_age_ms        (m_ranger_age_ms),
        .m_inertial_age_ms      (m_inertial_age_ms),
        .m_ranger_prompt        (m_ranger_prompt),
        .m_inertial_prompt      (m_inertial_prompt),
        .m_ranger_prompts_used  (m_ranger_prompts_used),
        .m_inertial_prompts_used(m_inertial_prompts_used)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Supervisor predictor
    // ------------------------------------------------------------------

    // A beat revives a dead source and clears its recovery
    function automatic void revive_on_beat(inout source_track_t s, input logic [31:0] now);
        s.last_beat = now;
        s.beat_seen = 1'b1;
        if (!s.alive) begin
            s.alive      = 1'b1;
            s.recovering = 1'b0;
            s.prompts    = 3'd0;
        end
    endfunction

    // Declare death once the last beat is too old; silent until a first beat
    function automatic void check_heartbeat(inout source_track_t s, input logic [31:0] now);
        if (s.beat_seen && s.alive && (now - s.last_beat) > {16'd0, hb_timeout_cfg}) begin
            s.alive      = 1'b0;
            s.recovering = 1'b1;
            s.rec_start  = now;
        end
    endfunction

    function automatic void grade_reading(inout source_track_t s, input logic [31:0] now,
                                          input logic [15:0] limit);
        if (!s.read_seen)
            s.data_health = HEALTH_DEAD;
        else if ((now - s.last_read) > {16'd0, limit})
            s.data_health = HEALTH_DEGRADED;
        else
            s.data_health = HEALTH_OK;
    endfunction

    // Issue a prompt once the grace time has run, up to the prompt limit
    function automatic logic issue_prompt(inout source_track_t s, input logic [31:0] now);
        if (s.alive || !s.recovering)
            return 1'b0;
        if ((now - s.rec_start) < {16'd0, grace_cfg})
            return 1'b0;
        if (s.prompts >= max_prompts_cfg)
            return 1'b0;
        s.prompts   = s.prompts + 3'd1;
        s.rec_start = now;
        return 1'b1;
    endfunction

    function automatic snapshot_t supervise_item(sensor_item_t it);
        snapshot_t snap;
        logic      r_pr;
        logic      i_pr;
        r_pr = 1'b0;
        i_pr = 1'b0;
        case (it.req)
            REQ_RANGER_BEAT: revive_on_beat(ranger_st, it.now);
            REQ_INERTIAL_BEAT: revive_on_beat(inertial_st, it.now);
            REQ_TICK: begin
                check_heartbeat(ranger_st, it.now);
                check_heartbeat(inertial_st, it.now);
                grade_reading(ranger_st, it.now, r_deadline_cfg);
                grade_reading(inertial_st, it.now, i_deadline_cfg);
                r_pr = issue_prompt(ranger_st, it.now);
                i_pr = issue_prompt(inertial_st, it.now);
                if (!ranger_st.alive || !inertial_st.alive)
                    mode_m = MODE_SAFE_STOP;
                else if (ranger_st.data_health != HEALTH_OK ||
                         inertial_st.data_health != HEALTH_OK)
                    mode_m = MODE_DEGRADED;
                else
                    mode_m = MODE_NORMAL;
            end
            REQ_RANGER_READ: begin
                ranger_st.last_read = it.now;
                ranger_st.read_seen = 1'b1;
                // a disconnected reading keeps distance and override
                if (it.connected) begin
                    distance_m = {1'b0, it.range_mm};
                    override_m = it.range_mm < obstacle_cfg;
                end
            end
            REQ_INERTIAL_READ: begin
                inertial_st.last_read = it.now;
                inertial_st.read_seen = 1'b1;
            end
            default: ;
        endcase
        snap.mode        = mode_m;
        snap.override_on = override_m;
        snap.r_health    = ranger_st.alive ? ranger_st.data_health : HEALTH_DEAD;
        snap.i_health    = inertial_st.alive ? inertial_st.data_health : HEALTH_DEAD;
        snap.distance    = distance_m;
        snap.r_age       = ranger_st.read_seen ? it.now - ranger_st.last_read : 32'd0;
        snap.i_age       = inertial_st.read_seen ? it.now - inertial_st.last_read : 32'd0;
        snap.r_prompt    = r_pr;
        snap.i_prompt    = i_pr;
        snap.r_used      = ranger_st.prompts;
        snap.i_used      = inertial_st.prompts;
        return snap;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic add_item(input logic [2:0] req, input logic [31:0] now,
                            input logic [15:0] range_mm = 16'd0,
                            input logic connected = 1'b0, input logic imu_ok = 1'b0);
        sensor_item_t it;
        it.req       = req;
        it.now       = now;
        it.range_mm  = range_mm;
        it.connected = connected;
        it.imu_ok    = imu_ok;
        item_q.push_back(it);
    endtask

    // Random well-formed traffic: advancing time, regular beats and readings,
    // with occasional outages of either source and rare wild time jumps
    task automatic queue_random_items(input int count, input int unsigned step_max,
                                      input logic [31:0] start_ms);
        sensor_item_t it;
        logic [31:0]  clock_ms;
        int           r_out;
        int           i_out;
        int           roll;
        clock_ms = start_ms;
        r_out    = 0;
        i_out    = 0;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                clock_ms = $urandom;
            else if (roll < 10)
                clock_ms = clock_ms + $urandom_range(0, 4 * step_max);
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);

            if (r_out > 0) r_out--;
            else if ($urandom_range(0, 99) < 3) r_out = $urandom_range(10, 60);
            if (i_out > 0) i_out--;
            else if ($urandom_range(0, 99) < 3) i_out = $urandom_range(10, 60);

            it.now       = clock_ms;
            it.range_mm  = $urandom_range(0, 1) ? obstacle_cfg + 16'($urandom_range(0, 4)) - 16'd2
                                                : 16'($urandom);
            it.connected = ($urandom_range(0, 9) != 0);
            it.imu_ok    = 1'($urandom_range(0, 1));

            // a source in outage goes quiet; its slot becomes a tick
            roll = $urandom_range(0, 99);
            if (roll < 30)
                it.req = REQ_TICK;
            else if (roll < 45)
                it.req = (r_out > 0) ? REQ_TICK : REQ_RANGER_BEAT;
            else if (roll < 60)
                it.req = (i_out > 0) ? REQ_TICK : REQ_INERTIAL_BEAT;
            else if (roll < 75)
                it.req = (r_out > 0) ? REQ_TICK : REQ_RANGER_READ;
            else if (roll < 88)
                it.req = (i_out > 0) ? REQ_TICK : REQ_INERTIAL_READ;
            else if (roll < 95)
                it.req = REQ_QUERY;
            else
                it.req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
            item_q.push_back(it);
        end
    endtask

    // Setup then access phase; upper data bits carry junk the block must mask
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom;
        if (idx == REG_MAX_PROMPTS)
            word[2:0] = value[2:0];
        else
            word[15:0] = value;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HB_TIMEOUT:   hb_timeout_cfg  = word[15:0];
            REG_R_DEADLINE:   r_deadline_cfg  = word[15:0];
            REG_I_DEADLINE:   i_deadline_cfg  = word[15:0];
            REG_GRACE:        grace_cfg       = word[15:0];
            REG_MAX_PROMPTS:  max_prompts_cfg = word[2:0];
            REG_OBSTACLE_THR: obstacle_cfg    = word[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] hb, input logic [15:0] r_dl,
                                 input logic [15:0] i_dl, input logic [15:0] grace,
                                 input logic [2:0] max_pr, input logic [15:0] thr);
        write_reg(REG_HB_TIMEOUT, hb);
        write_reg(REG_R_DEADLINE, r_dl);
        write_reg(REG_I_DEADLINE, i_dl);
        write_reg(REG_GRACE, grace);
        write_reg(REG_MAX_PROMPTS, {13'd0, max_pr});
        write_reg(REG_OBSTACLE_THR, thr);
    endtask

    // Hold until every item is in and every snapshot is out
    task automatic wait_idle();
        while (item_q.size() != 0 || s_valid || snapshot_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        ranger_st   = '{1'b0, 1'b0, 32'd0, 1'b0, 32'd0, HEALTH_DEAD, 1'b0, 32'd0, 3'd0};
        inertial_st = ranger_st;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk at reset settings: first snapshot in recovery mode,
        // a tick before any beat, spare codes, disconnected reading, distance
        // extremes and threshold edge, death, the full prompt budget, revival
        // and time wrap
        add_item(REQ_QUERY, 32'd0);
        add_item(REQ_TICK, 32'd5);
        add_item(REQ_SPARE_A, 32'd10, 16'hFFFF, 1'b1, 1'b1);
        add_item(REQ_SPARE_B, 32'd12);
        add_item(REQ_RANGER_BEAT, 32'd20);
        add_item(REQ_INERTIAL_BEAT, 32'd20);
        add_item(REQ_RANGER_READ, 32'd30, 16'd0, 1'b1);
        add_item(REQ_RANGER_READ, 32'd40, 16'hFFFF, 1'b0);
        add_item(REQ_RANGER_READ, 32'd50, 16'hFFFF, 1'b1);
        add_item(REQ_INERTIAL_READ, 32'd60, 16'd0, 1'b0, 1'b1);
        add_item(REQ_INERTIAL_READ, 32'd61, 16'd0, 1'b0, 1'b0);
        add_item(REQ_TICK, 32'd100);
        add_item(REQ_TICK, 32'd401);
        add_item(REQ_TICK, 32'd2401);
        add_item(REQ_TICK, 32'd4401);
        add_item(REQ_TICK, 32'd6401);
        add_item(REQ_TICK, 32'd8401);
        add_item(REQ_RANGER_BEAT, 32'd8500);
        add_item(REQ_QUERY, 32'hFFFF_FFF0);
        add_item(REQ_RANGER_READ, 32'hFFFF_FFFF, 16'd199, 1'b1);
        add_item(REQ_RANGER_READ, 32'hFFFF_FFFF, 16'd200, 1'b1);
        add_item(REQ_INERTIAL_BEAT, 32'hFFFF_FFFF);
        add_item(REQ_RANGER_BEAT, 32'hFFFF_FFFF);
        add_item(REQ_TICK, 32'd5);
        add_item(REQ_QUERY, 32'd6);
        wait_idle();

        // Short timeouts so sources die and recover often
        apply_setting(16'd40, 16'd60, 16'd90, 16'd100, 3'd3, 16'd200);
        write_reg(REG_SPARE, 16'($urandom));
        queue_random_items(190, 30, $urandom);
        wait_idle();

        // Every register at its lowest, time crossing the wrap
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 16'd0);
        queue_random_items(190, 3, 32'hFFFF_FF00);
        wait_idle();

        // Every register at its highest
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF);
        queue_random_items(190, 20000, $urandom);
        wait_idle();

        // No grace and the largest prompt budget, so counters saturate
        apply_setting(16'd20, 16'd30, 16'd25, 16'd0, 3'd7, 16'd30000);
        queue_random_items(190, 15, $urandom);
        wait_idle();

        apply_setting(16'd100, 16'd150, 16'd80, 16'd300, 3'd2, 16'd1000);
        queue_random_items(190, 80, $urandom);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && snapshot_q.size() == 0)
            $display("dual_sensor_safety_watchdog_tb: done, clean");
        else
            $display("dual_sensor_safety_watchdog_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present queued items, predict each one on its transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                snapshot_q.push_back(supervise_item(offered));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    offered = item_q.pop_front();
                    s_valid            <= 1'b1;
                    s_req_type         <= offered.req;
                    s_now_ms           <= offered.now;
                    s_distance_mm      <= offered.range_mm;
                    s_ranger_connected <= offered.connected;
                    s_inertial_valid   <= offered.imu_ok;
                    send_gap = pick_gap(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each snapshot and pace the result side
    // ------------------------------------------------------------------
    function automatic void compare_field(input string label, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                snapshots_seen++;
                if (snapshot_q.size() == 0) begin
                    $display("%0t: snapshot with no item outstanding", $time);
                    mismatch_count++;
                end else begin
                    snapshot_t want;
                    want = snapshot_q.pop_front();
                    compare_field("system_mode", want.mode, m_system_mode);
                    compare_field("override_on", want.override_on, m_override_on);
                    compare_field("ranger_health", want.r_health, m_ranger_health);
                    compare_field("inertial_health", want.i_health, m_inertial_health);
                    compare_field("last_distance_mm", want.distance, m_last_distance_mm);
                    compare_field("ranger_age_ms", want.r_age, m_ranger_age_ms);
                    compare_field("inertial_age_ms", want.i_age, m_inertial_age_ms);
                    compare_field("ranger_prompt", want.r_prompt, m_ranger_prompt);
                    compare_field("inertial_prompt", want.i_prompt, m_inertial_prompt);
                    compare_field("ranger_prompts_used", want.r_used, m_ranger_prompts_used);
                    compare_field("inertial_prompts_used", want.i_used,
                                  m_inertial_prompts_used);
                end
            end
            // one long hold-off mid-run lets the block back up into its input
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && snapshots_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap(recv_burst);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("dual_sensor_safety_watchdog_tb: done, errors");
                $finish;
            end
        end
    end

endmodule

[dual_sensor_safety_watchdog.f]
+incdir+rtl/core
rtl/core/dsw_pkg.sv
rtl/core/dsw_regs.sv
rtl/core/dsw_source.sv
rtl/core/dual_sensor_safety_watchdog.sv
sim/dual_sensor_safety_watchdog_tb.sv
